[src/catpb_pkg.sv]
// Package for the circle/arc two-point break unit.
// Holds angle constants, command codes, the CORDIC arctangent table and angle helpers.
// No dependencies.
`default_nettype none
package catpb_pkg;

   localparam int COORD_WIDTH_DEFAULT   = 32;
   localparam int CORDIC_STAGES_DEFAULT = 24;

   localparam int ANGLE_WIDTH = 25;
   localparam int Z_WIDTH     = 26;
   localparam int TOL_WIDTH   = 16;
   localparam int CMD_WIDTH   = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_CIRCLE = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_ARC    = 2'd1;

   localparam logic [ANGLE_WIDTH-1:0] FULL_TURN = 25'd23592960;
   localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = 25'd11796480;

   localparam logic [21:0] ATAN_TABLE [32] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
      22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
      22'd1, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
   };

   // one correction into [0,360), argument in (-360,720)
   function automatic logic [ANGLE_WIDTH-1:0] wrap_angle(
      input logic signed [ANGLE_WIDTH+1:0] a);
      logic signed [ANGLE_WIDTH+1:0] ft;
      logic signed [ANGLE_WIDTH+1:0] r;
      ft = $signed({2'b00, FULL_TURN});
      if (a < 0) begin
         r = a + ft;
      end else if (a >= ft) begin
         r = a - ft;
      end else begin
         r = a;
      end
      return r[ANGLE_WIDTH-1:0];
   endfunction

   function automatic logic signed [ANGLE_WIDTH+1:0] angle_diff(
      input logic [ANGLE_WIDTH-1:0] a, input logic [ANGLE_WIDTH-1:0] b);
      return $signed({2'b00, a}) - $signed({2'b00, b});
   endfunction

   // circular distance from a ccw span
   function automatic logic [ANGLE_WIDTH-1:0] circ_min(input logic [ANGLE_WIDTH-1:0] s);
      logic [ANGLE_WIDTH-1:0] o;
      o = FULL_TURN - s;
      return (s < o) ? s : o;
   endfunction

endpackage
`default_nettype wire

[src/circle_arc_two_point_break_unit.sv]
// Top level of the circle/arc two-point break unit.
// Pipelined twin CORDIC angle finders followed by the arc cutting stages.
// Depends on catpb_pkg.
`default_nettype none
// One transaction may enter every cycle while busy is low. Results leave in order of
// acceptance; the receiver cannot stall. A transaction that leaves two arcs shows them
// in consecutive cycles, and during the first of those busy is high for one cycle while
// the whole pipeline holds, since there is a single result port.
module circle_arc_two_point_break_unit
   #(parameter int COORD_WIDTH   = catpb_pkg::COORD_WIDTH_DEFAULT,
     parameter int CORDIC_STAGES = catpb_pkg::CORDIC_STAGES_DEFAULT)
   (input  wire logic                                  clock,
    input  wire logic                                  reset,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [catpb_pkg::CMD_WIDTH-1:0]       req_command,
    input  wire logic signed [COORD_WIDTH-1:0]         req_center_x,
    input  wire logic signed [COORD_WIDTH-1:0]         req_center_y,
    input  wire logic signed [COORD_WIDTH-1:0]         req_radius,
    input  wire logic [catpb_pkg::ANGLE_WIDTH-1:0]     req_arc_start,
    input  wire logic [catpb_pkg::ANGLE_WIDTH-1:0]     req_arc_end,
    input  wire logic signed [COORD_WIDTH-1:0]         req_first_x,
    input  wire logic signed [COORD_WIDTH-1:0]         req_first_y,
    input  wire logic signed [COORD_WIDTH-1:0]         req_second_x,
    input  wire logic signed [COORD_WIDTH-1:0]         req_second_y,
    output logic                                       rsp_strobe,
    output logic [catpb_pkg::ANGLE_WIDTH-1:0]          rsp_part_start,
    output logic [catpb_pkg::ANGLE_WIDTH-1:0]          rsp_part_end,
    output logic                                       rsp_last_part,
    input  wire logic                                  csr_valid,
    output logic                                       csr_ready,
    input  wire logic [catpb_pkg::TOL_WIDTH-1:0]       csr_wdata);

   import catpb_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int XW = COORD_WIDTH + 3;
   localparam int NQ = 8;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]   cmd;
      logic                   rad_pos;
      logic [ANGLE_WIDTH-1:0] st;
      logic [ANGLE_WIDTH-1:0] en;
      logic [ANGLE_WIDTH-1:0] total;
   } ctx_type;

   typedef struct packed {
      ctx_type                ctx;
      logic [ANGLE_WIDTH-1:0] a1;
      logic [ANGLE_WIDTH-1:0] a2;
      logic [ANGLE_WIDTH-1:0] u1;
      logic [ANGLE_WIDTH-1:0] u2;
      logic [ANGLE_WIDTH-1:0] v1;
      logic [ANGLE_WIDTH-1:0] v2;
      logic [ANGLE_WIDTH-1:0] w1;
      logic [ANGLE_WIDTH-1:0] w2;
      logic [ANGLE_WIDTH-1:0] cd;
      logic                   keep1;
      logic                   keep2;
   } post_type;

   logic                   advance;
   logic                   stall;
   logic [TOL_WIDTH-1:0]   tol_ff;
   logic [ANGLE_WIDTH-1:0] tol;

   // ---------------- config
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_wdata;
      end
   end
   assign tol = {{(ANGLE_WIDTH-TOL_WIDTH){1'b0}}, tol_ff};

   // ---------------- input register
   logic                          iv_ff;
   logic [CMD_WIDTH-1:0]          icmd_ff;
   logic signed [COORD_WIDTH-1:0] icx_ff, icy_ff, irad_ff;
   logic signed [COORD_WIDTH-1:0] ip1x_ff, ip1y_ff, ip2x_ff, ip2y_ff;
   logic [ANGLE_WIDTH-1:0]        ist_ff, ien_ff;

   assign busy    = stall;
   assign advance = !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
      end else if (advance) begin
         iv_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         icmd_ff <= req_command;
         icx_ff  <= req_center_x;
         icy_ff  <= req_center_y;
         irad_ff <= req_radius;
         ist_ff  <= req_arc_start;
         ien_ff  <= req_arc_end;
         ip1x_ff <= req_first_x;
         ip1y_ff <= req_first_y;
         ip2x_ff <= req_second_x;
         ip2y_ff <= req_second_y;
      end
   end

   // ---------------- difference stage
   logic                 dv_ff;
   logic signed [DW-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   ctx_type              dctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (advance) begin
         dv_ff <= iv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1x_ff <= $signed({ip1x_ff[COORD_WIDTH-1], ip1x_ff})
                   - $signed({icx_ff[COORD_WIDTH-1], icx_ff});
         d1y_ff <= $signed({ip1y_ff[COORD_WIDTH-1], ip1y_ff})
                   - $signed({icy_ff[COORD_WIDTH-1], icy_ff});
         d2x_ff <= $signed({ip2x_ff[COORD_WIDTH-1], ip2x_ff})
                   - $signed({icx_ff[COORD_WIDTH-1], icx_ff});
         d2y_ff <= $signed({ip2y_ff[COORD_WIDTH-1], ip2y_ff})
                   - $signed({icy_ff[COORD_WIDTH-1], icy_ff});
         dctx_ff.cmd     <= icmd_ff;
         dctx_ff.rad_pos <= !irad_ff[COORD_WIDTH-1] && (irad_ff != '0);
         dctx_ff.st      <= wrap_angle($signed({2'b00, ist_ff}));
         dctx_ff.en      <= wrap_angle($signed({2'b00, ien_ff}));
         dctx_ff.total   <= '0;
      end
   end

   // ---------------- CORDIC: index 0 is the half-turn pre-rotation
   logic                       cv_ff  [0:CORDIC_STAGES];
   ctx_type                    cctx_ff[0:CORDIC_STAGES];
   logic signed [XW-1:0]       x1_ff  [0:CORDIC_STAGES];
   logic signed [XW-1:0]       y1_ff  [0:CORDIC_STAGES];
   logic signed [Z_WIDTH-1:0]  z1_ff  [0:CORDIC_STAGES];
   logic signed [XW-1:0]       x2_ff  [0:CORDIC_STAGES];
   logic signed [XW-1:0]       y2_ff  [0:CORDIC_STAGES];
   logic signed [Z_WIDTH-1:0]  z2_ff  [0:CORDIC_STAGES];
   ctx_type                    cctx0_in;

   logic signed [XW-1:0] d1x_e, d1y_e, d2x_e, d2y_e;
   assign d1x_e = XW'(d1x_ff);
   assign d1y_e = XW'(d1y_ff);
   assign d2x_e = XW'(d2x_ff);
   assign d2y_e = XW'(d2y_ff);

   always_comb begin
      cctx0_in       = dctx_ff;
      cctx0_in.total = wrap_angle(angle_diff(dctx_ff.en, dctx_ff.st));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (advance) begin
         cv_ff[0] <= dv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cctx_ff[0] <= cctx0_in;
         if (d1x_ff < 0) begin
            x1_ff[0] <= -d1x_e;
            y1_ff[0] <= -d1y_e;
            z1_ff[0] <= $signed({1'b0, HALF_TURN});
         end else begin
            x1_ff[0] <= d1x_e;
            y1_ff[0] <= d1y_e;
            z1_ff[0] <= '0;
         end
         if (d2x_ff < 0) begin
            x2_ff[0] <= -d2x_e;
            y2_ff[0] <= -d2y_e;
            z2_ff[0] <= $signed({1'b0, HALF_TURN});
         end else begin
            x2_ff[0] <= d2x_e;
            y2_ff[0] <= d2y_e;
            z2_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      logic signed [Z_WIDTH-1:0] atan_z;
      logic signed [XW-1:0]      xs1, ys1, xs2, ys2;
      assign atan_z = $signed({{(Z_WIDTH-22){1'b0}}, ATAN_TABLE[i]});
      assign xs1 = x1_ff[i] >>> i;
      assign ys1 = y1_ff[i] >>> i;
      assign xs2 = x2_ff[i] >>> i;
      assign ys2 = y2_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (advance) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            cctx_ff[i+1] <= cctx_ff[i];
            if (y1_ff[i] > 0) begin
               x1_ff[i+1] <= x1_ff[i] + ys1;
               y1_ff[i+1] <= y1_ff[i] - xs1;
               z1_ff[i+1] <= z1_ff[i] + atan_z;
            end else if (y1_ff[i] < 0) begin
               x1_ff[i+1] <= x1_ff[i] - ys1;
               y1_ff[i+1] <= y1_ff[i] + xs1;
               z1_ff[i+1] <= z1_ff[i] - atan_z;
            end else begin
               x1_ff[i+1] <= x1_ff[i];
               y1_ff[i+1] <= y1_ff[i];
               z1_ff[i+1] <= z1_ff[i];
            end
            if (y2_ff[i] > 0) begin
               x2_ff[i+1] <= x2_ff[i] + ys2;
               y2_ff[i+1] <= y2_ff[i] - xs2;
               z2_ff[i+1] <= z2_ff[i] + atan_z;
            end else if (y2_ff[i] < 0) begin
               x2_ff[i+1] <= x2_ff[i] - ys2;
               y2_ff[i+1] <= y2_ff[i] + xs2;
               z2_ff[i+1] <= z2_ff[i] - atan_z;
            end else begin
               x2_ff[i+1] <= x2_ff[i];
               y2_ff[i+1] <= y2_ff[i];
               z2_ff[i+1] <= z2_ff[i];
            end
         end
      end
   end

   // ---------------- arc cutting stages
   logic     qv_ff [1:NQ];
   post_type q_ff  [1:NQ];
   post_type q_in  [1:NQ];

   always_comb begin
      q_in[1]     = '0;
      q_in[1].ctx = cctx_ff[CORDIC_STAGES];
      q_in[1].a1  = wrap_angle((ANGLE_WIDTH+2)'(z1_ff[CORDIC_STAGES]));
      q_in[1].a2  = wrap_angle((ANGLE_WIDTH+2)'(z2_ff[CORDIC_STAGES]));

      // ccw spans
      q_in[2]    = q_ff[1];
      q_in[2].cd = wrap_angle(angle_diff(q_ff[1].a2, q_ff[1].a1));
      q_in[2].u1 = wrap_angle(angle_diff(q_ff[1].a1, q_ff[1].ctx.st));
      q_in[2].u2 = wrap_angle(angle_diff(q_ff[1].a2, q_ff[1].ctx.st));

      // distance to start, span to end
      q_in[3]    = q_ff[2];
      q_in[3].cd = circ_min(q_ff[2].cd);
      q_in[3].v1 = circ_min(q_ff[2].u1);
      q_in[3].v2 = circ_min(q_ff[2].u2);
      q_in[3].w1 = wrap_angle(angle_diff(q_ff[2].ctx.total, q_ff[2].u1));
      q_in[3].w2 = wrap_angle(angle_diff(q_ff[2].ctx.total, q_ff[2].u2));

      q_in[4]    = q_ff[3];
      q_in[4].w1 = circ_min(q_ff[3].w1);
      q_in[4].w2 = circ_min(q_ff[3].w2);

      // clamp to nearer end; u holds the parameter afterwards
      q_in[5] = q_ff[4];
      if (q_ff[4].u1 > q_ff[4].ctx.total) begin
         q_in[5].u1 = (q_ff[4].v1 <= q_ff[4].w1) ? '0 : q_ff[4].ctx.total;
      end
      if (q_ff[4].u2 > q_ff[4].ctx.total) begin
         q_in[5].u2 = (q_ff[4].v2 <= q_ff[4].w2) ? '0 : q_ff[4].ctx.total;
      end

      // sort: u1 low, u2 high
      q_in[6] = q_ff[5];
      if (q_ff[5].u1 > q_ff[5].u2) begin
         q_in[6].u1 = q_ff[5].u2;
         q_in[6].u2 = q_ff[5].u1;
      end

      q_in[7] = q_ff[6];
      unique case (q_ff[6].ctx.cmd)
         CMD_CIRCLE: begin
            q_in[7].keep1 = q_ff[6].cd > tol;
            q_in[7].keep2 = 1'b0;
         end
         CMD_ARC: begin
            if (!q_ff[6].ctx.rad_pos || q_ff[6].ctx.total <= tol ||
                ((q_ff[6].u2 - q_ff[6].u1) <= tol &&
                 (q_ff[6].u1 <= tol ||
                  ({1'b0, q_ff[6].u1} + {1'b0, tol}) >= {1'b0, q_ff[6].ctx.total}))) begin
               q_in[7].keep1 = 1'b0;
               q_in[7].keep2 = 1'b0;
            end else begin
               q_in[7].keep1 = q_ff[6].u1 > tol;
               q_in[7].keep2 = (q_ff[6].ctx.total - q_ff[6].u2) > tol;
            end
         end
         default: begin
            q_in[7].keep1 = 1'b0;
            q_in[7].keep2 = 1'b0;
         end
      endcase

      // result angles: v1/w1 first arc, v2/w2 second arc
      q_in[8] = q_ff[7];
      if (q_ff[7].ctx.cmd == CMD_CIRCLE) begin
         q_in[8].v1 = q_ff[7].a2;
         q_in[8].w1 = q_ff[7].a1;
      end else begin
         q_in[8].v1 = q_ff[7].ctx.st;
         q_in[8].w1 = wrap_angle($signed({2'b00, q_ff[7].ctx.st})
                                 + $signed({2'b00, q_ff[7].u1}));
      end
      q_in[8].v2 = wrap_angle($signed({2'b00, q_ff[7].ctx.st})
                              + $signed({2'b00, q_ff[7].u2}));
      q_in[8].w2 = q_ff[7].ctx.en;
   end

   for (genvar k = 1; k <= NQ; k++) begin : g_post
      logic v_in;
      if (k == 1) begin : g_first
         assign v_in = cv_ff[CORDIC_STAGES];
      end else begin : g_rest
         assign v_in = qv_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qv_ff[k] <= 1'b0;
         end else if (advance) begin
            qv_ff[k] <= v_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            q_ff[k] <= q_in[k];
         end
      end
   end

   // ---------------- result port
   logic half_ff;
   logic half_in;
   logic use_second;

   assign stall   = qv_ff[NQ] && q_ff[NQ].keep1 && q_ff[NQ].keep2 && !half_ff;
   assign half_in = stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 1'b0;
      end else begin
         half_ff <= half_in;
      end
   end

   assign use_second     = half_ff || !q_ff[NQ].keep1;
   assign rsp_strobe     = qv_ff[NQ] && (q_ff[NQ].keep1 || q_ff[NQ].keep2);
   assign rsp_part_start = use_second ? q_ff[NQ].v2 : q_ff[NQ].v1;
   assign rsp_part_end   = use_second ? q_ff[NQ].w2 : q_ff[NQ].w1;
   assign rsp_last_part  = use_second || !q_ff[NQ].keep2;

endmodule
`default_nettype wire

[src/catpb_checker.sv]
// Port-level checker for the circle/arc two-point break unit, with its bind.
// Depends on catpb_pkg and circle_arc_two_point_break_unit.
`default_nettype none
module catpb_checker
   (input wire logic                              clock,
    input wire logic                              reset,
    input wire logic                              busy,
    input wire logic                              rsp_strobe,
    input wire logic [catpb_pkg::ANGLE_WIDTH-1:0] rsp_part_start,
    input wire logic [catpb_pkg::ANGLE_WIDTH-1:0] rsp_part_end,
    input wire logic                              rsp_last_part);

   import catpb_pkg::*;

   // busy only while the first of two arcs is out
   a_busy_first: assert property (@(posedge clock) disable iff (reset)
      busy |-> rsp_strobe && !rsp_last_part)
      else $error("busy without a first arc on the port");

   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_part |=> rsp_strobe && rsp_last_part)
      else $error("second arc missing after first");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_part_start < FULL_TURN && rsp_part_end < FULL_TURN)
      else $error("result angle out of range");

endmodule

bind circle_arc_two_point_break_unit catpb_checker u_catpb_checker (.*);
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for circle_arc_two_point_break_unit: directed and random break
// transactions in several tolerance/idle phases, checked against an in-bench predictor.
// Depends on catpb_pkg and the unit's RTL.
`timescale 1ns / 100ps
module testbench;
   import catpb_pkg::*;

   localparam int     STAGES  = CORDIC_STAGES_DEFAULT;
   localparam int     LATENCY = STAGES + 11;
   localparam longint TURN    = longint'(FULL_TURN);
   localparam longint HALF    = longint'(HALF_TURN);
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_A = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_B = 2'd3;

   typedef struct {
      logic [CMD_WIDTH-1:0]   cmd;
      logic signed [31:0]     cx, cy, rad, fx, fy, sx, sy;
      logic [ANGLE_WIDTH-1:0] st, en;
   } break_req_type;

   typedef struct {
      logic [ANGLE_WIDTH-1:0] ps, pe;
      logic                   last;
   } arc_piece_type;

   logic clock, reset, start, busy;
   logic [CMD_WIDTH-1:0]   req_command;
   logic signed [31:0]     req_center_x, req_center_y, req_radius;
   logic [ANGLE_WIDTH-1:0] req_arc_start, req_arc_end;
   logic signed [31:0]     req_first_x, req_first_y, req_second_x, req_second_y;
   logic                   rsp_strobe, rsp_last_part;
   logic [ANGLE_WIDTH-1:0] rsp_part_start, rsp_part_end;
   logic                   csr_valid, csr_ready;
   logic [TOL_WIDTH-1:0]   csr_wdata;

   break_req_type pending[$];
   arc_piece_type expected_pieces[$];
   longint     tolerance;
   int         issued_n, accepted_n, piece_n, error_n, idle_pct;
   int         circle_n, arc_n;

   circle_arc_two_point_break_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_center_x(req_center_x),
      .req_center_y(req_center_y), .req_radius(req_radius),
      .req_arc_start(req_arc_start), .req_arc_end(req_arc_end),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .rsp_strobe(rsp_strobe), .rsp_part_start(rsp_part_start),
      .rsp_part_end(rsp_part_end), .rsp_last_part(rsp_last_part),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata));

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint wrap_turn(longint a);
      longint r;
      r = a % TURN;
      return (r < 0) ? r + TURN : r;
   endfunction

   function automatic longint arc_dist(longint a, longint b);
      longint sp;
      sp = wrap_turn(b - a);
      return (sp < TURN - sp) ? sp : TURN - sp;
   endfunction

   function automatic longint bearing(longint cx, longint cy, longint px, longint py);
      longint x, y, z, xs, ys;
      x = px - cx;
      y = py - cy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HALF;
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ATAN_TABLE[i]);
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ATAN_TABLE[i]);
         end
      end
      return wrap_turn(z);
   endfunction

   function automatic longint clamp_param(longint st, longint total, longint pa);
      longint p;
      p = wrap_turn(pa - st);
      if (p <= total) return p;
      return (arc_dist(pa, st) <= arc_dist(pa, st + total)) ? 0 : total;
   endfunction

   task automatic queue_item(input break_req_type r);
      pending.insert(pending.size(), r);
   endtask

   task automatic predict_break(input break_req_type r);
      longint a1, a2, st, en, total, p1, p2, t;
      arc_piece_type pc[$];
      arc_piece_type one;
      a1 = bearing(r.cx, r.cy, r.fx, r.fy);
      a2 = bearing(r.cx, r.cy, r.sx, r.sy);
      st = wrap_turn(longint'(r.st));
      en = wrap_turn(longint'(r.en));
      if (r.cmd == CMD_CIRCLE) begin
         circle_n++;
         if (arc_dist(a1, a2) > tolerance) begin
            one.ps = a2[ANGLE_WIDTH-1:0];
            one.pe = a1[ANGLE_WIDTH-1:0];
            one.last = 1'b1;
            expected_pieces.insert(expected_pieces.size(), one);
         end
      end else if (r.cmd == CMD_ARC) begin
         arc_n++;
         total = wrap_turn(en - st);
         if (r.rad > 0 && total > tolerance) begin
            p1 = clamp_param(st, total, a1);
            p2 = clamp_param(st, total, a2);
            if (p1 > p2) begin
               t = p1;
               p1 = p2;
               p2 = t;
            end
            if (!(p2 - p1 <= tolerance && (p1 <= tolerance || p1 >= total - tolerance))) begin
               if (p1 > tolerance) begin
                  one.ps = ANGLE_WIDTH'(wrap_turn(st));
                  one.pe = ANGLE_WIDTH'(wrap_turn(st + p1));
                  one.last = 1'b0;
                  pc.insert(pc.size(), one);
               end
               if (total - p2 > tolerance) begin
                  one.ps = ANGLE_WIDTH'(wrap_turn(st + p2));
                  one.pe = ANGLE_WIDTH'(wrap_turn(st + total));
                  one.last = 1'b0;
                  pc.insert(pc.size(), one);
               end
               if (pc.size() > 0) pc[pc.size()-1].last = 1'b1;
               foreach (pc[i]) expected_pieces.insert(expected_pieces.size(), pc[i]);
            end
         end
      end
   endtask

   // driver: new transaction offered at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted_n == issued_n) begin
         if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
            break_req_type r;
            r = pending.pop_front();
            req_command <= r.cmd;
            req_center_x <= r.cx;
            req_center_y <= r.cy;
            req_radius <= r.rad;
            req_arc_start <= r.st;
            req_arc_end <= r.en;
            req_first_x <= r.fx;
            req_first_y <= r.fy;
            req_second_x <= r.sx;
            req_second_y <= r.sy;
            start <= 1'b1;
            issued_n++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         break_req_type r;
         r.cmd = req_command;
         r.cx = req_center_x;
         r.cy = req_center_y;
         r.rad = req_radius;
         r.st = req_arc_start;
         r.en = req_arc_end;
         r.fx = req_first_x;
         r.fy = req_first_y;
         r.sx = req_second_x;
         r.sy = req_second_y;
         predict_break(r);
         accepted_n++;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         arc_piece_type e;
         piece_n++;
         if (expected_pieces.size() == 0) begin
            error_n++;
            $display("%0t: unexpected arc start=%0d end=%0d last=%0b", $time,
                     rsp_part_start, rsp_part_end, rsp_last_part);
         end else begin
            e = expected_pieces.pop_front();
            if (rsp_part_start !== e.ps || rsp_part_end !== e.pe || rsp_last_part !== e.last) begin
               error_n++;
               $display("%0t: arc mismatch exp start=%0d end=%0d last=%0b got %0d %0d %0b",
                        $time, e.ps, e.pe, e.last, rsp_part_start, rsp_part_end,
                        rsp_last_part);
            end
         end
      end
   end

   function automatic break_req_type mk(logic [CMD_WIDTH-1:0] cmd, longint cx, longint cy,
         longint rad, longint st, longint en, longint fx, longint fy, longint sx, longint sy);
      break_req_type r;
      r.cmd = cmd;
      r.cx = 32'(cx);
      r.cy = 32'(cy);
      r.rad = 32'(rad);
      r.st = ANGLE_WIDTH'(st);
      r.en = ANGLE_WIDTH'(en);
      r.fx = 32'(fx);
      r.fy = 32'(fy);
      r.sx = 32'(sx);
      r.sy = 32'(sy);
      return r;
   endfunction

   task automatic on_circle(input longint cx, input longint cy, input real rad,
         input real deg, output longint px, output longint py);
      real th;
      th = deg * 3.14159265358979 / 180.0;
      px = cx + longint'($rtoi(rad * $cos(th)));
      py = cy + longint'($rtoi(rad * $sin(th)));
   endtask

   function automatic logic signed [31:0] rnd32();
      return $signed($urandom());
   endfunction

   task automatic push_directed();
      longint u, v, w, z;
      queue_item(mk(CMD_CIRCLE, 0, 0, 65536, 0, 0, 65536, 0, 0, 65536));
      queue_item(mk(CMD_CIRCLE, 0, 0, 0, 0, 0, 65536, 65536, 65536, 65536));
      queue_item(mk(CMD_CIRCLE, 0, 0, -5, 0, 0, 0, 0, -65536, 0));
      queue_item(mk(CMD_CIRCLE, -32'sh80000000, 32'sh7fffffff, 1, 0, 0,
                    32'sh7fffffff, -32'sh80000000, -32'sh80000000, -32'sh80000000));
      queue_item(mk(CMD_CIRCLE, 32'sh7fffffff, -32'sh80000000, 1, 0, 0,
                    -32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      queue_item(mk(CMD_ARC, 0, 0, 65536, 0, TURN - 1, 65536, 65536, -65536, -65536));
      queue_item(mk(CMD_ARC, 0, 0, 65536, 33554431, TURN, 0, 65536, 0, -65536));
      queue_item(mk(CMD_ARC, 0, 0, 0, 0, HALF, 65536, 65536, -65536, 65536));
      queue_item(mk(CMD_ARC, 0, 0, -32'sh80000000, 0, HALF, 65536, 65536, 0, 65536));
      queue_item(mk(CMD_ARC, 0, 0, 32'sh7fffffff, 1000, 1000, 65536, 65536, 0, 65536));
      queue_item(mk(CMD_ARC, 0, 0, 65536, TURN - 5898240, 5898240,
                    65536, 0, 65536, -65536));
      queue_item(mk(CMD_ARC, 0, 0, 65536, 0, HALF, 0, -65536, 65536, -65536));
      queue_item(mk(CMD_ARC, 0, 0, 65536, 0, HALF, 65536, 0, 65536, 0));
      queue_item(mk(CMD_ARC, 0, 0, 65536, 0, HALF, -65536, 0, -65536, -1));
      queue_item(mk(CMD_ARC, 0, 0, 65536, 0, HALF, 0, 65536, 65536, 65536));
      queue_item(mk(CMD_ARC, 0, 0, 65536, 0, HALF, 65536, 65536, 65536, 1));
      queue_item(mk(CMD_ARC, 100, 100, 65536, 0, HALF, 100, 100, 100, 100));
      queue_item(mk(CMD_SPARE_A, 0, 0, 65536, 0, HALF, 65536, 0, 0, 65536));
      queue_item(mk(CMD_SPARE_B, 0, 0, 65536, 0, HALF, 65536, 0, 0, 65536));
      on_circle(0, 0, 1.0e6, 90.0 + 1.0 / 65536.0, u, v);
      on_circle(0, 0, 1.0e6, 180.0 - 1.0 / 65536.0, w, z);
      queue_item(mk(CMD_ARC, 0, 0, 1000000, 0, HALF, u, v, w, z));
   endtask

   task automatic push_random(input int count);
      break_req_type r;
      real rad, s_deg, span_deg;
      longint st, en;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 75) begin
            r.cmd = $urandom_range(1) ? CMD_ARC : CMD_CIRCLE;
            r.cx = $signed($urandom()) >>> $urandom_range(12, 4);
            r.cy = $signed($urandom()) >>> $urandom_range(12, 4);
            rad = real'($urandom_range(1 << ($urandom_range(24, 8)), 16));
            r.rad = $rtoi(rad);
            st = $urandom_range(32'(TURN - 1));
            en = $urandom_range(32'(TURN - 1));
            if ($urandom_range(9) == 0) en = wrap_turn(st + $urandom_range(40));
            if ($urandom_range(9) == 0) st = st + TURN + ($urandom_range(9) > 0 ? 0 : 1);
            r.st = ANGLE_WIDTH'((st > 33554431) ? 33554431 : st);
            r.en = ANGLE_WIDTH'(en);
            s_deg = real'(wrap_turn(longint'(r.st))) / 65536.0;
            span_deg = real'(wrap_turn(en - wrap_turn(longint'(r.st)))) / 65536.0;
            begin
               longint px, py;
               real d;
               case ($urandom_range(5))
                  0: d = 0.0;
                  1: d = span_deg - real'($urandom_range(200)) / 65536.0;
                  2: d = span_deg + real'($urandom_range(7200)) / 100.0;
                  default: d = span_deg * real'($urandom_range(1000)) / 1000.0;
               endcase
               on_circle(r.cx, r.cy, rad, s_deg + d, px, py);
               r.fx = 32'(px);
               r.fy = 32'(py);
               case ($urandom_range(5))
                  0: begin
                     r.sx = r.fx + $signed($urandom_range(4)) - 2;
                     r.sy = r.fy;
                  end
                  1: d = -real'($urandom_range(7200)) / 100.0;
                  default: d = span_deg * real'($urandom_range(1000)) / 1000.0;
               endcase
               on_circle(r.cx, r.cy, rad * 1.5, s_deg + d, px, py);
               if (r.sx != r.fx + 2 && r.sx != r.fx - 2 && r.sy != r.fy) begin
                  r.sx = 32'(px);
                  r.sy = 32'(py);
               end
            end
            if ($urandom_range(19) == 0) r.rad = -r.rad;
         end else begin
            r.cmd = CMD_WIDTH'($urandom_range(3));
            r.cx = rnd32();
            r.cy = rnd32();
            r.rad = rnd32();
            r.st = ANGLE_WIDTH'($urandom_range(33554431));
            r.en = ANGLE_WIDTH'($urandom_range(33554431));
            r.fx = rnd32();
            r.fy = rnd32();
            r.sx = rnd32();
            r.sy = rnd32();
            if ($urandom_range(7) == 0) begin
               r.fx = r.cx;
               r.fy = r.cy;
            end
         end
         queue_item(r);
      end
   endtask

   task automatic drain();
      while (pending.size() > 0 || accepted_n != issued_n || expected_pieces.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_WIDTH-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      tolerance = longint'(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [TOL_WIDTH-1:0] tol_set [6];
      int idle_set [6];
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      req_command = CMD_CIRCLE;
      {req_center_x, req_center_y, req_radius, req_first_x} = '0;
      {req_first_y, req_second_x, req_second_y} = '0;
      {req_arc_start, req_arc_end} = '0;
      tolerance = 0;
      issued_n = 0;
      accepted_n = 0;
      piece_n = 0;
      error_n = 0;
      circle_n = 0;
      arc_n = 0;
      idle_pct = 0;
      tol_set = '{16'd0, 16'hffff, 16'd100, 16'($urandom()), 16'd1, 16'd0};
      idle_set = '{0, 57, 0, 37, 57, 37};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         write_tolerance(tol_set[ph]);
         idle_pct = idle_set[ph];
         if (ph == 0 || ph == 2 || ph == 4) push_directed();
         push_random(107);
         drain();
      end
      $display("Ran %0d transactions (%0d circle, %0d arc) over six tolerance/idle phases,",
               accepted_n, circle_n, arc_n);
      $display("checked %0d result arcs, %0d mismatching.", piece_n, error_n);
      if (error_n == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Timeout with %0d transactions accepted.", accepted_n);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[circle_arc_two_point_break_unit.f]
src/catpb_pkg.sv
src/circle_arc_two_point_break_unit.sv
src/catpb_checker.sv
bench/testbench.sv
